// ===== rtl/multi_keyword_match_counter_macros.svh =====
// assertion macros for the keyword match counter checker
`ifndef MULTI_KEYWORD_MATCH_COUNTER_MACROS_SVH
`define MULTI_KEYWORD_MATCH_COUNTER_MACROS_SVH

// clocked property, masked while reset is low
`define MKMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain condition checked at every edge
`define MKMC_ASSERT_ALWAYS(lbl, cond, msg) `MKMC_ASSERT(lbl, cond, msg)

`endif

// ===== rtl/mkmc_pkg.sv =====
// shared constants for the keyword match counter
package mkmc_pkg;

  localparam int OP_W     = 3;
  localparam int LETTER_W = 7;
  localparam int TOTAL_W  = 16;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd0;
  localparam logic [OP_W-1:0] OP_KEY_LETTER = 3'd1;
  localparam logic [OP_W-1:0] OP_KEY_END    = 3'd2;
  localparam logic [OP_W-1:0] OP_BUILD      = 3'd3;
  localparam logic [OP_W-1:0] OP_TEXT       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

  localparam logic [LETTER_W-1:0] LETTER_BASE = 7'd97;
  localparam logic [TOTAL_W-1:0]  SAT16       = 16'hFFFF;

endpackage

// ===== rtl/mkmc_ram.sv =====
// single write, single read port memory with registered read data
module mkmc_ram #(
  parameter int W = 10,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/multi_keyword_match_counter.sv =====
// top level: keyword trie, failure-link build and text scan sequencer
//
//  channel | ports                                   | transaction
//  --------+-----------------------------------------+---------------------------
//  input   | start, busy, in_op, in_letter           | start & !busy at clk edge
//  result  | out_valid, out_match_total, out_status  | out_valid, one cycle only
//
// one shared child-address unit (node * ALPHABET + letter) feeds the trie memory;
// every memory read has an issue state and a data state, as the read data is registered
// a keyword letter that allocates a node also sweeps the new node's child row (row sweep);
// clear sweeps the root row; refused, out-of-alphabet and unused ops keep busy low
// text letter: follows failure steps, then sums the suffix nodes, and stops at the root
// or on a node that was already counted
// build: reads every child of each node and follows failure steps for each child
// after reset the root row is swept with busy high;
// the result strobe follows the last busy cycle and cannot be stalled
module multi_keyword_match_counter #(
  parameter int NODES    = 1024,
  parameter int ALPHABET = 26
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [mkmc_pkg::OP_W-1:0]        in_op,
  input  logic [mkmc_pkg::LETTER_W-1:0]    in_letter,
  output logic                             out_valid,
  output logic [mkmc_pkg::TOTAL_W-1:0]     out_match_total,
  output logic [mkmc_pkg::STATUS_W-1:0]    out_status
);

  import mkmc_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int CW = $clog2(ALPHABET);
  localparam int CD = NODES * ALPHABET;
  localparam int AW = $clog2(CD);

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_INS_RD, S_INS, S_END_RD, S_END,
    S_B_POP, S_B_POPW, S_B_CH, S_B_CHW, S_B_FRD, S_B_FW, S_B_KRD, S_B_KW,
    S_S_CH, S_S_CHW, S_S_FRD, S_S_FW, S_S_T, S_S_TW
  } state_t;

  state_t              state_r;
  logic [NW-1:0]       clr_row_r;
  logic [CW-1:0]       c_r;
  logic                clr_res_r;
  logic [NW:0]         nodes_used_r;
  logic [NW-1:0]       cursor_r;
  logic [NW-1:0]       match_r;
  logic [TOTAL_W-1:0]  total_r;
  logic                built_r;
  logic [NW:0]         head_r;
  logic [NW:0]         tail_r;
  logic [NW-1:0]       p_r;
  logic [NW-1:0]       f_r;
  logic [NW-1:0]       ch_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;

  // memory ports
  logic [AW-1:0]      child_addr;
  logic               child_we;
  logic [NW-1:0]      child_wdata;
  logic [NW-1:0]      child_rdata;
  logic               fail_we;
  logic [NW-1:0]      fail_waddr;
  logic [NW-1:0]      fail_wdata;
  logic [NW-1:0]      fail_raddr;
  logic [NW-1:0]      fail_rdata;
  logic               cnt_we;
  logic [NW-1:0]      cnt_waddr;
  logic [TOTAL_W-1:0] cnt_wdata;
  logic [NW-1:0]      cnt_raddr;
  logic [TOTAL_W-1:0] cnt_rdata;
  logic               mark_we;
  logic [NW-1:0]      mark_waddr;
  logic               mark_wdata;
  logic               mark_rdata;
  logic               q_we;
  logic [NW-1:0]      q_waddr;
  logic [NW-1:0]      q_wdata;
  logic [NW-1:0]      q_rdata;

  logic [NW-1:0]         node_sel;
  logic [LETTER_W-1:0]   idx7;
  logic                  letter_ok;
  logic [CW-1:0]         cidx;
  logic                  accept;
  logic                  can_alloc;
  logic [NW-1:0]         new_node;
  logic                  b_commit;
  logic [NW-1:0]         b_child;
  logic [TOTAL_W:0]      sum17;
  logic [TOTAL_W-1:0]    sum_sat;
  logic                  last_c;

  assign accept    = start && (state_r == S_IDLE);
  assign idx7      = in_letter - LETTER_BASE;
  assign letter_ok = (in_letter >= LETTER_BASE) && (idx7 < LETTER_W'(ALPHABET));
  assign cidx      = idx7[CW-1:0];
  assign can_alloc = nodes_used_r < (NW+1)'(NODES);
  assign new_node  = nodes_used_r[NW-1:0];
  assign last_c    = (c_r == CW'(ALPHABET - 1));
  assign sum17     = {1'b0, total_r} + {1'b0, cnt_rdata};
  assign sum_sat   = sum17[TOTAL_W] ? SAT16 : sum17[TOTAL_W-1:0];

  // shared child address unit: which node's row is addressed
  always_comb begin
    unique case (state_r)
      S_CLR:                  node_sel = clr_row_r;
      S_INS_RD, S_INS:        node_sel = cursor_r;
      S_B_KRD, S_B_KW:        node_sel = f_r;
      default:                node_sel = p_r;
    endcase
  end

  assign child_addr = AW'(node_sel) * AW'(ALPHABET) + AW'(c_r);

  // new trie edge on allocation, zero rows during sweeps
  assign child_we    = (state_r == S_CLR) ||
                       ((state_r == S_INS) && (child_rdata == '0) && can_alloc);
  assign child_wdata = (state_r == S_CLR) ? '0 : new_node;

  // build: a child gets its failure target and joins the queue
  always_comb begin
    b_commit = 1'b0;
    b_child  = ch_r;
    if ((state_r == S_B_CHW) && (child_rdata != '0) && (p_r == '0)) begin
      b_commit = 1'b1;
      b_child  = child_rdata;
    end else if ((state_r == S_B_KW) && ((child_rdata != '0) || (f_r == '0))) begin
      b_commit = 1'b1;
    end
  end

  logic alloc_now;
  assign alloc_now = (state_r == S_INS) && (child_rdata == '0) && can_alloc;

  assign fail_we    = alloc_now || b_commit;
  assign fail_waddr = alloc_now ? new_node : b_child;
  assign fail_wdata = (alloc_now || (state_r == S_B_CHW)) ? '0 : child_rdata;
  assign fail_raddr = (state_r == S_S_FRD) ? p_r : f_r;

  assign cnt_we    = alloc_now || (state_r == S_END);
  assign cnt_waddr = alloc_now ? new_node : cursor_r;
  assign cnt_wdata = alloc_now ? '0 :
                     ((cnt_rdata == SAT16) ? SAT16 : cnt_rdata + TOTAL_W'(1));
  assign cnt_raddr = (state_r == S_END_RD) ? cursor_r : f_r;

  assign mark_we    = alloc_now || ((state_r == S_S_TW) && !mark_rdata);
  assign mark_waddr = alloc_now ? new_node : f_r;
  assign mark_wdata = !alloc_now;

  // root seeds the queue when a build is accepted
  assign q_we    = (accept && (in_op == OP_BUILD)) ||
                   (b_commit && (tail_r < (NW+1)'(NODES)));
  assign q_waddr = (state_r == S_IDLE) ? '0 : tail_r[NW-1:0];
  assign q_wdata = (state_r == S_IDLE) ? '0 : b_child;

  mkmc_ram #(.W(NW), .D(CD)) u_child (
    .clk(clk), .we(child_we), .waddr(child_addr), .wdata(child_wdata),
    .raddr(child_addr), .rdata(child_rdata)
  );
  mkmc_ram #(.W(NW), .D(NODES)) u_fail (
    .clk(clk), .we(fail_we), .waddr(fail_waddr), .wdata(fail_wdata),
    .raddr(fail_raddr), .rdata(fail_rdata)
  );
  mkmc_ram #(.W(TOTAL_W), .D(NODES)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );
  mkmc_ram #(.W(1), .D(NODES)) u_mark (
    .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(f_r), .rdata(mark_rdata)
  );
  mkmc_ram #(.W(NW), .D(NODES)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(head_r[NW-1:0]), .rdata(q_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_row_r    <= '0;
      c_r          <= '0;
      clr_res_r    <= 1'b0;
      nodes_used_r <= (NW+1)'(1);
      cursor_r     <= '0;
      match_r      <= '0;
      total_r      <= '0;
      built_r      <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            unique case (in_op)
              OP_CLEAR: begin
                nodes_used_r <= (NW+1)'(1);
                cursor_r     <= '0;
                match_r      <= '0;
                total_r      <= '0;
                built_r      <= 1'b0;
                clr_row_r    <= '0;
                c_r          <= '0;
                clr_res_r    <= 1'b1;
                state_r      <= S_CLR;
              end
              OP_KEY_LETTER: begin
                if (built_r || !letter_ok) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= built_r ? ST_REFUSED : ST_OK;
                end else begin
                  c_r     <= cidx;
                  state_r <= S_INS_RD;
                end
              end
              OP_KEY_END: begin
                if (built_r) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_REFUSED;
                end else begin
                  state_r <= S_END_RD;
                end
              end
              OP_BUILD: begin
                head_r  <= '0;
                tail_r  <= (NW+1)'(1);
                state_r <= S_B_POP;
              end
              OP_TEXT: begin
                if (!letter_ok) begin
                  match_r      <= '0;
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_OK;
                end else begin
                  c_r     <= cidx;
                  p_r     <= match_r;
                  state_r <= S_S_CH;
                end
              end
              default: begin
                out_valid_r  <= 1'b1;
                out_status_r <= ST_OK;
              end
            endcase
          end
        end
        // zero one child row, one entry a cycle
        S_CLR: begin
          if (last_c) begin
            state_r <= S_IDLE;
            if (clr_res_r) begin
              out_valid_r  <= 1'b1;
              out_status_r <= ST_OK;
            end
          end else begin
            c_r <= c_r + CW'(1);
          end
        end
        S_INS_RD: state_r <= S_INS;
        S_INS: begin
          if (child_rdata != '0) begin
            cursor_r     <= child_rdata;
            out_valid_r  <= 1'b1;
            out_status_r <= ST_OK;
            state_r      <= S_IDLE;
          end else if (can_alloc) begin
            nodes_used_r <= nodes_used_r + (NW+1)'(1);
            cursor_r     <= new_node;
            clr_row_r    <= new_node;
            c_r          <= '0;
            clr_res_r    <= 1'b1;
            state_r      <= S_CLR;
          end else begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_FULL;
            state_r      <= S_IDLE;
          end
        end
        S_END_RD: state_r <= S_END;
        S_END: begin
          cursor_r     <= '0;
          out_valid_r  <= 1'b1;
          out_status_r <= ST_OK;
          state_r      <= S_IDLE;
        end
        // breadth-first failure link build
        S_B_POP: begin
          if (head_r == tail_r) begin
            built_r      <= 1'b1;
            match_r      <= '0;
            out_valid_r  <= 1'b1;
            out_status_r <= ST_OK;
            state_r      <= S_IDLE;
          end else begin
            head_r  <= head_r + (NW+1)'(1);
            state_r <= S_B_POPW;
          end
        end
        S_B_POPW: begin
          p_r     <= q_rdata;
          c_r     <= '0;
          state_r <= S_B_CH;
        end
        S_B_CH: state_r <= S_B_CHW;
        S_B_CHW: begin
          ch_r <= child_rdata;
          if ((child_rdata != '0) && (p_r != '0)) begin
            f_r     <= p_r;
            state_r <= S_B_FRD;
          end else begin
            if (b_commit && (tail_r < (NW+1)'(NODES))) begin
              tail_r <= tail_r + (NW+1)'(1);
            end
            c_r     <= c_r + CW'(!last_c);
            state_r <= last_c ? S_B_POP : S_B_CH;
          end
        end
        S_B_FRD: state_r <= S_B_FW;
        S_B_FW: begin
          f_r     <= fail_rdata;
          state_r <= S_B_KRD;
        end
        S_B_KRD: state_r <= S_B_KW;
        S_B_KW: begin
          if (b_commit) begin
            if (tail_r < (NW+1)'(NODES)) begin
              tail_r <= tail_r + (NW+1)'(1);
            end
            c_r     <= c_r + CW'(!last_c);
            state_r <= last_c ? S_B_POP : S_B_CH;
          end else begin
            state_r <= S_B_FRD;
          end
        end
        // text letter: follow failure edges, then sum the suffix chain
        S_S_CH: state_r <= S_S_CHW;
        S_S_CHW: begin
          if ((child_rdata != '0) || (p_r == '0)) begin
            match_r <= child_rdata;
            f_r     <= child_rdata;
            state_r <= S_S_T;
          end else begin
            state_r <= S_S_FRD;
          end
        end
        S_S_FRD: state_r <= S_S_FW;
        S_S_FW: begin
          p_r     <= fail_rdata;
          state_r <= S_S_CH;
        end
        S_S_T: begin
          if (f_r == '0) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_OK;
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_S_TW;
          end
        end
        S_S_TW: begin
          if (mark_rdata) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_OK;
            state_r      <= S_IDLE;
          end else begin
            total_r <= sum_sat;
            f_r     <= fail_rdata;
            state_r <= S_S_T;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  // total only moves while busy, so it is stable in the strobe cycle
  assign out_match_total = total_r;

endmodule

// ===== rtl/mkmc_checker.sv =====
// port-level checker for the keyword match counter, bound to the top level
`include "multi_keyword_match_counter_macros.svh"

module mkmc_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // a result only follows an accepted item or sequencer work
  `MKMC_ASSERT(a_result_has_cause, out_valid |-> $past(start || busy), "result without work")
  // the block is ready again when it shows a result
  `MKMC_ASSERT_ALWAYS(a_result_idle, out_valid |-> !busy, "busy during result strobe")
  // one strobe per transaction
  `MKMC_ASSERT(a_single_strobe, out_valid && !start |=> !out_valid, "result repeated")

endmodule

bind multi_keyword_match_counter mkmc_checker u_mkmc_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid)
);

// ===== verif/tb.sv =====
// self-checking testbench for the multi keyword match counter
`timescale 1ns / 100ps

module tb;
  import mkmc_pkg::*;

  localparam int NODES     = 1024;
  localparam int ALPHABET  = 26;
  localparam int RAND_GOAL = 900;
  localparam int LIMIT     = 3000000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [OP_W-1:0]     in_op = OP_CLEAR;
  logic [LETTER_W-1:0] in_letter = '0;
  logic                out_valid;
  logic [TOTAL_W-1:0]  out_match_total;
  logic [STATUS_W-1:0] out_status;

  multi_keyword_match_counter #(.NODES(NODES), .ALPHABET(ALPHABET)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_letter(in_letter),
    .out_valid(out_valid), .out_match_total(out_match_total), .out_status(out_status)
  );

  always #1 clk = ~clk;

  // expected total and status for each accepted transaction
  typedef struct packed {
    logic [TOTAL_W-1:0]  total;
    logic [STATUS_W-1:0] status;
  } answer_t;

  answer_t answers_due[$];
  int      errors = 0;
  int      cycles = 0;
  int      accepted = 0;
  int      results_seen = 0;
  int      matches_seen = 0;
  bit      quiet = 1'b0;      // no idle bursts in the closing stretch
  bit      typed_valid = 1'b0;
  answer_t typed_answer;

  // shadow copy of the trie, failure links and counters
  logic [9:0]  kids [NODES*ALPHABET];
  logic [9:0]  fail_to [NODES];
  logic [15:0] kw_hits [NODES];
  bit          seen_node [NODES];
  logic [9:0]  walk_q [NODES];
  int          node_cnt;
  logic [9:0]  ins_at;
  logic [9:0]  scan_at;
  logic [15:0] total_now;
  bit          linked;

  function automatic void trie_clear();
    foreach (kids[i]) kids[i] = '0;
    foreach (fail_to[i]) begin
      fail_to[i] = '0;
      kw_hits[i] = '0;
      seen_node[i] = 1'b0;
    end
    node_cnt = 1;
    ins_at = '0;
    scan_at = '0;
    total_now = '0;
    linked = 1'b0;
  endfunction

  function automatic logic [9:0] kid(logic [9:0] n, int c);
    return kids[n*ALPHABET + c];
  endfunction

  // breadth-first pass that fills in the failure links
  function automatic void trie_link();
    int head, tail, c, g;
    logic [9:0] p, ch, f, hit;
    head = 0;
    tail = 1;
    walk_q[0] = '0;
    fail_to[0] = '0;
    while (head != tail) begin
      p = walk_q[head];
      head++;
      for (c = 0; c < ALPHABET; c++) begin
        ch = kid(p, c);
        if (ch == 0) continue;
        hit = '0;
        if (p != 0) begin
          f = fail_to[p];
          for (g = 0; g <= NODES; g++) begin
            if (kid(f, c) != 0) begin
              hit = kid(f, c);
              break;
            end
            if (f == 0) break;
            f = fail_to[f];
          end
        end
        fail_to[ch] = hit;
        if (tail < NODES) begin
          walk_q[tail] = ch;
          tail++;
        end
      end
    end
    linked = 1'b1;
    scan_at = '0;
  endfunction

  function automatic void trie_scan(logic [LETTER_W-1:0] letter);
    int c, g;
    logic [9:0] p;
    logic [16:0] sum;
    if (letter < LETTER_BASE || letter >= LETTER_BASE + ALPHABET) begin
      scan_at = '0;
      return;
    end
    c = letter - LETTER_BASE;
    p = scan_at;
    for (g = 0; g <= NODES && p != 0 && kid(p, c) == 0; g++) p = fail_to[p];
    p = kid(p, c);
    scan_at = p;
    for (g = 0; g <= NODES && p != 0 && !seen_node[p]; g++) begin
      sum = total_now + kw_hits[p];
      total_now = (sum > SAT16) ? SAT16 : sum[15:0];
      seen_node[p] = 1'b1;
      p = fail_to[p];
    end
  endfunction

  // advance the shadow state by one transaction and return its answer
  function automatic answer_t trie_step(logic [OP_W-1:0] op, logic [LETTER_W-1:0] letter);
    answer_t a;
    int c;
    logic [STATUS_W-1:0] st;
    st = ST_OK;
    case (op)
      OP_CLEAR: trie_clear();
      OP_KEY_LETTER: begin
        if (linked) st = ST_REFUSED;
        else if (letter >= LETTER_BASE && letter < LETTER_BASE + ALPHABET) begin
          c = letter - LETTER_BASE;
          if (kid(ins_at, c) != 0) ins_at = kid(ins_at, c);
          else if (node_cnt < NODES) begin
            kids[ins_at*ALPHABET + c] = node_cnt[9:0];
            ins_at = node_cnt[9:0];
            node_cnt++;
          end else st = ST_FULL;
        end
      end
      OP_KEY_END: begin
        if (linked) st = ST_REFUSED;
        else begin
          if (kw_hits[ins_at] != SAT16) kw_hits[ins_at]++;
          ins_at = '0;
        end
      end
      OP_BUILD: trie_link();
      OP_TEXT: trie_scan(letter);
      default: ;
    endcase
    a.total = total_now;
    a.status = st;
    return a;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  // one process both records accepted transactions and checks results, so the
  // order of the two within an edge is fixed
  always @(posedge clk) begin
    answer_t a, want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, answers_due.size());
      $display("tb failed");
      $finish;
    end
    if (rst_n && start && !busy) begin
      a = trie_step(in_op, in_letter);
      answers_due.push_back(typed_valid ? typed_answer : a);
      accepted++;
    end
    if (rst_n && out_valid) begin
      results_seen++;
      if (answers_due.size() == 0) begin
        $display("unexpected result: total %0d status %0d", out_match_total, out_status);
        errors++;
      end else begin
        want = answers_due.pop_front();
        if (out_match_total !== want.total) report("match_total", out_match_total, want.total);
        if (out_status !== want.status) report("status", out_status, want.status);
        if (out_match_total != 0 && out_status == ST_OK) matches_seen++;
      end
    end
  end

  // drive one transaction at the falling edge and hold it until accepted
  task automatic issue(logic [OP_W-1:0] op, logic [LETTER_W-1:0] letter);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_op <= op;
    in_letter <= letter;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [LETTER_W-1:0] pick_letter(int span);
    if ($urandom_range(0, 19) == 0) return LETTER_W'($urandom_range(0, 127));
    return LETTER_W'(LETTER_BASE + $urandom_range(0, span - 1));
  endfunction

  // directed rows: typed answers only where they are obvious
  typedef struct {
    logic [OP_W-1:0]     op;
    logic [LETTER_W-1:0] letter;
    bit                  typed;
    logic [TOTAL_W-1:0]  total;
    logic [STATUS_W-1:0] status;
  } row_t;

  row_t rows[] = '{
    '{OP_TEXT,       7'd97,  1, 16'd0, ST_OK},      // scan on empty trie
    '{3'd5,          7'd0,   1, 16'd0, ST_OK},      // unused op codes
    '{3'd7,          7'd127, 1, 16'd0, ST_OK},
    '{3'd6,          7'd42,  1, 16'd0, ST_OK},
    '{OP_KEY_LETTER, 7'd0,   1, 16'd0, ST_OK},      // letter outside alphabet
    '{OP_KEY_END,    7'd0,   1, 16'd0, ST_OK},      // empty keyword counts on root
    '{OP_KEY_LETTER, 7'd97,  0, 16'd0, ST_OK},      // "ab"
    '{OP_KEY_LETTER, 7'd98,  0, 16'd0, ST_OK},
    '{OP_KEY_END,    7'd0,   0, 16'd0, ST_OK},
    '{OP_KEY_LETTER, 7'd98,  0, 16'd0, ST_OK},      // "b" twice
    '{OP_KEY_END,    7'd0,   0, 16'd0, ST_OK},
    '{OP_KEY_LETTER, 7'd98,  0, 16'd0, ST_OK},
    '{OP_KEY_END,    7'd0,   0, 16'd0, ST_OK},
    '{OP_KEY_LETTER, 7'd122, 0, 16'd0, ST_OK},      // "z"
    '{OP_KEY_END,    7'd0,   0, 16'd0, ST_OK},
    '{OP_TEXT,       7'd98,  0, 16'd0, ST_OK},      // scan before links exist
    '{OP_BUILD,      7'd0,   0, 16'd0, ST_OK},
    '{OP_TEXT,       7'd97,  0, 16'd0, ST_OK},
    '{OP_TEXT,       7'd98,  0, 16'd0, ST_OK},
    '{OP_TEXT,       7'd123, 0, 16'd0, ST_OK},      // outside alphabet drops to root
    '{OP_TEXT,       7'd122, 0, 16'd0, ST_OK},
    '{OP_CLEAR,      7'd0,   1, 16'd0, ST_OK},
    '{OP_BUILD,      7'd0,   1, 16'd0, ST_OK},
    '{OP_KEY_LETTER, 7'd113, 1, 16'd0, ST_REFUSED}, // insert after build
    '{OP_KEY_END,    7'd0,   1, 16'd0, ST_REFUSED}
  };

  // one dictionary: clear, keywords, optional early scan, build, scan text, optional refused insert and rebuild
  task automatic run_dictionary(int span);
    int nkw, len, i, j;
    issue(OP_CLEAR, LETTER_W'($urandom_range(0, 127)));
    nkw = $urandom_range(1, 6);
    for (i = 0; i < nkw; i++) begin
      len = $urandom_range(0, 4);
      for (j = 0; j < len; j++) issue(OP_KEY_LETTER, pick_letter(span));
      issue(OP_KEY_END, LETTER_W'($urandom_range(0, 127)));
      if ($urandom_range(0, 9) == 0) issue(OP_TEXT, pick_letter(span));
      if ($urandom_range(0, 14) == 0) issue(3'($urandom_range(5, 7)), pick_letter(span));
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 6)) issue(OP_TEXT, pick_letter(span));
    issue(OP_BUILD, LETTER_W'($urandom_range(0, 127)));
    repeat ($urandom_range(8, 30)) issue(OP_TEXT, pick_letter(span));
    if ($urandom_range(0, 5) == 0) begin
      issue($urandom_range(0, 1) ? OP_KEY_LETTER : OP_KEY_END, pick_letter(span));
      issue(OP_TEXT, pick_letter(span));
    end
    if ($urandom_range(0, 5) == 0) begin
      issue(OP_BUILD, '0);
      repeat ($urandom_range(3, 10)) issue(OP_TEXT, pick_letter(span));
    end
  endtask

  initial begin
    trie_clear();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // typed answer changes only after the monitor has taken the previous one
    foreach (rows[i]) begin
      typed_answer.total <= rows[i].total;
      typed_answer.status <= rows[i].status;
      typed_valid <= rows[i].typed;
      issue(rows[i].op, rows[i].letter);
    end
    typed_valid <= 1'b0;

    // random dictionaries, mostly over a few letters so keywords actually hit
    while (accepted < RAND_GOAL) begin
      if (accepted > RAND_GOAL - 120) quiet = 1'b1;
      run_dictionary($urandom_range(0, 3) == 0 ? ALPHABET : $urandom_range(2, 4));
    end

    @(negedge clk);
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("%0d transactions accepted, %0d results checked, %0d with a nonzero total",
             accepted, results_seen, matches_seen);
    $display("covered empty tries, early scans, rebuilds, refused inserts and stray letters");
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mkmc_pkg.sv
rtl/mkmc_ram.sv
rtl/multi_keyword_match_counter.sv
rtl/mkmc_checker.sv
verif/tb.sv
